// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Field widths, action codes and sequencer states shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int IDX_BITS     = 10;
   localparam int CORNER_BITS  = 11;
   localparam int COORD_BITS   = 20;
   localparam int SUM_BITS     = 48;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int CROSS_BITS   = 2 * DIFF_BITS + 1;
   localparam int MAG_BITS     = 30;
   localparam int MUL_BITS     = MAG_BITS + 1;
   localparam int PROD_BITS    = 2 * MUL_BITS;
   localparam int ROOT_BITS    = PROD_BITS + 1;
   localparam int LEN_BITS     = MAG_BITS + 1;
   localparam int FRAC_BITS    = 14;
   localparam int QUO_BITS     = FRAC_BITS + 1;
   localparam int NUM_BITS     = MAG_BITS + FRAC_BITS + 1;
   localparam int NORM_BITS    = 16;
   localparam int CNT_BITS     = 5;
   localparam int SQRT_STEPS   = LEN_BITS;

   localparam int REQ_DATA_BITS = 104;
   localparam int REQ_USER_BITS = 2;
   localparam int RSP_DATA_BITS = 3 * NORM_BITS;
   localparam int RSP_USER_BITS = 2;

   localparam int VI_LSB = 0;
   localparam int PX_LSB = VI_LSB + IDX_BITS;
   localparam int PY_LSB = PX_LSB + COORD_BITS;
   localparam int PZ_LSB = PY_LSB + COORD_BITS;
   localparam int CA_LSB = PZ_LSB + COORD_BITS;
   localparam int CB_LSB = CA_LSB + CORNER_BITS;
   localparam int CC_LSB = CB_LSB + CORNER_BITS;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_TRI  = 2'd1,
      ACT_READ = 2'd2,
      ACT_NOP  = 2'd3
   } action_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOAD,
      S_TRI_RD,
      S_TRI_DIFF,
      S_TRI_MUL,
      S_SUM_RD,
      S_SUM_WAIT,
      S_SUM_ADD,
      S_SUM_WR,
      S_RD_RD,
      S_RD_WAIT,
      S_SHIFT,
      S_SQ,
      S_SQRT,
      S_DIV_INIT,
      S_DIV,
      S_DIV_END,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/vertex_normal_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Stores vertex positions, accumulates triangle cross products into per-vertex
// sums with saturation and returns normalized vertex normals in Q1.14.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// req_*     in         action in tuser, vertex and triangle fields in tdata
// rsp_*     out        normal in tdata, skipped and saturated flags in tuser
// csr_*     in         vertex count register write
//
// A triangle does three position reads, six products on the shared multiplier
// and three read-modify-writes of the sum memory. A read runs the shift search,
// the 31-step square root and three 15-step divisions. Reset is synchronous and
// clears the sequencer, the output valid flag and the vertex count; memories are
// not cleared. A waiting result does not block acceptance of the next request.
`default_nettype none

module vertex_normal_accumulator_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, pad
   input  wire logic [vna_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // action
   input  wire logic [vna_pkg::REQ_USER_BITS-1:0]   req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // normal_x, normal_y, normal_z
   output logic [vna_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   // triangle_skipped, sum_saturated
   output logic [vna_pkg::RSP_USER_BITS-1:0]        rsp_tuser,
   input  wire logic                                csr_wr_en,
   input  wire logic [vna_pkg::CORNER_BITS-1:0]     csr_wr_data
);
   import vna_pkg::*;

   `include "assert_macros.svh"

   localparam logic [SUM_BITS-1:0] MAG_LIMIT = SUM_BITS'(1) << MAG_BITS;
   localparam logic signed [SUM_BITS-1:0] SUM_HI = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_LO = {1'b1, {(SUM_BITS-1){1'b0}}};

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [1:0] ci_ff;
   logic [CORNER_BITS-1:0] vcount_ff;

   logic [IDX_BITS-1:0] vi_ff;
   logic [2:0][COORD_BITS-1:0] pos_ff;
   logic [2:0][CORNER_BITS-1:0] corner_ff;

   logic [2:0][COORD_BITS-1:0] pos_mem [MAX_VERTICES];
   logic [2:0][COORD_BITS-1:0] pos_rd_ff;
   logic [2:0][SUM_BITS-1:0] sum_mem [MAX_VERTICES];
   logic [2:0][SUM_BITS-1:0] sum_rd_ff;

   logic [2:0][COORD_BITS-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [DIFF_BITS-1:0] da_ff [3];
   logic signed [DIFF_BITS-1:0] db_ff [3];
   logic signed [CROSS_BITS-1:0] cross_ff [3];
   logic [2:0][SUM_BITS-1:0] row_ff;

   logic signed [MUL_BITS-1:0] mul_a, mul_b;
   logic signed [PROD_BITS-1:0] prod_ff;

   logic [SUM_BITS-1:0] m_ff [3];
   logic [SUM_BITS-1:0] big_ff;
   logic [2:0] neg_ff;
   logic [PROD_BITS-1:0] len2_ff;
   logic [ROOT_BITS-1:0] res_ff, bit_ff, root_n;
   logic [NUM_BITS-1:0] rem_ff, trial;
   logic [QUO_BITS-1:0] quo_ff;
   logic [3:0] div_shift;

   logic signed [NORM_BITS-1:0] norm_ff [3];
   logic skip_ff, sat_ff;

   logic rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [RSP_USER_BITS-1:0] rsp_user_ff;

   logic req_accept, out_free, tri_ok;
   logic pos_we, sum_we;
   logic [IDX_BITS-1:0] pos_raddr, sum_raddr, sum_waddr;
   logic [2:0][SUM_BITS-1:0] sum_wdata;
   logic [CORNER_BITS-1:0] corner_cur;
   logic [1:0] cnt_lo;
   logic [SUM_BITS-1:0] rd_mag [3];
   logic [SUM_BITS-1:0] rd_big;
   logic [CORNER_BITS-1:0] req_ca, req_cb, req_cc;
   logic signed [SUM_BITS:0] add_sum;

   function automatic logic [SUM_BITS-1:0] mag_of(input logic [SUM_BITS-1:0] v);
      logic [SUM_BITS-1:0] r;
      r = v[SUM_BITS-1] ? (~v + SUM_BITS'(1)) : v;
      return r;
   endfunction

   assign req_ca = req_tdata[CA_LSB +: CORNER_BITS];
   assign req_cb = req_tdata[CB_LSB +: CORNER_BITS];
   assign req_cc = req_tdata[CC_LSB +: CORNER_BITS];
   assign tri_ok = (req_ca < vcount_ff) && (req_cb < vcount_ff) && (req_cc < vcount_ff)
      && (req_ca < CORNER_BITS'(MAX_VERTICES)) && (req_cb < CORNER_BITS'(MAX_VERTICES))
      && (req_cc < CORNER_BITS'(MAX_VERTICES));

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cnt_lo = cnt_ff[1:0];
   assign div_shift = 4'(QUO_BITS - 1) - cnt_ff[3:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (action_type'(req_tuser))
                  ACT_LOAD: state_in = S_LOAD;
                  ACT_TRI:  state_in = tri_ok ? S_TRI_RD : S_OUT;
                  ACT_READ: state_in = S_RD_RD;
                  default:  state_in = S_OUT;
               endcase
            end
         end
         S_LOAD:     state_in = S_OUT;
         S_TRI_RD:   if (cnt_ff == CNT_BITS'(3)) state_in = S_TRI_DIFF;
         S_TRI_DIFF: state_in = S_TRI_MUL;
         S_TRI_MUL:  if (cnt_ff == CNT_BITS'(6)) state_in = S_SUM_RD;
         S_SUM_RD:   state_in = S_SUM_WAIT;
         S_SUM_WAIT: state_in = S_SUM_ADD;
         S_SUM_ADD:  if (cnt_ff == CNT_BITS'(2)) state_in = S_SUM_WR;
         S_SUM_WR:   state_in = (ci_ff == 2'd2) ? S_OUT : S_SUM_RD;
         S_RD_RD:    state_in = S_RD_WAIT;
         S_RD_WAIT:  state_in = S_SHIFT;
         S_SHIFT:    if (big_ff < MAG_LIMIT) state_in = S_SQ;
         S_SQ:       if (cnt_ff == CNT_BITS'(3)) state_in = S_SQRT;
         S_SQRT:     if (cnt_ff == CNT_BITS'(SQRT_STEPS - 1)) state_in = S_DIV_INIT;
         S_DIV_INIT: state_in = S_DIV;
         S_DIV:      if (cnt_ff == CNT_BITS'(QUO_BITS - 1)) state_in = S_DIV_END;
         S_DIV_END:  state_in = (ci_ff == 2'd2) ? S_OUT : S_DIV_INIT;
         S_OUT:      if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Memory control, multiplier operands and adder.
   always_comb begin
      pos_we = (state_ff == S_LOAD);
      sum_we = (state_ff == S_LOAD) || (state_ff == S_SUM_WR);
      case (ci_ff)
         2'd0:    corner_cur = corner_ff[0];
         2'd1:    corner_cur = corner_ff[1];
         default: corner_cur = corner_ff[2];
      endcase
      case (cnt_lo)
         2'd0:    pos_raddr = corner_ff[0][IDX_BITS-1:0];
         2'd1:    pos_raddr = corner_ff[1][IDX_BITS-1:0];
         default: pos_raddr = corner_ff[2][IDX_BITS-1:0];
      endcase
      sum_raddr = (state_ff == S_RD_RD) ? vi_ff : corner_cur[IDX_BITS-1:0];
      sum_waddr = (state_ff == S_LOAD) ? vi_ff : corner_cur[IDX_BITS-1:0];
      sum_wdata = (state_ff == S_LOAD) ? '0 : row_ff;

      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_TRI_MUL) begin
         case (cnt_ff[2:0])
            3'd0: begin mul_a = MUL_BITS'(da_ff[1]); mul_b = MUL_BITS'(db_ff[2]); end
            3'd1: begin mul_a = MUL_BITS'(da_ff[2]); mul_b = MUL_BITS'(db_ff[1]); end
            3'd2: begin mul_a = MUL_BITS'(da_ff[2]); mul_b = MUL_BITS'(db_ff[0]); end
            3'd3: begin mul_a = MUL_BITS'(da_ff[0]); mul_b = MUL_BITS'(db_ff[2]); end
            3'd4: begin mul_a = MUL_BITS'(da_ff[0]); mul_b = MUL_BITS'(db_ff[1]); end
            3'd5: begin mul_a = MUL_BITS'(da_ff[1]); mul_b = MUL_BITS'(db_ff[0]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == S_SQ) begin
         case (cnt_lo)
            2'd0:    mul_a = {1'b0, m_ff[0][MAG_BITS-1:0]};
            2'd1:    mul_a = {1'b0, m_ff[1][MAG_BITS-1:0]};
            default: mul_a = {1'b0, m_ff[2][MAG_BITS-1:0]};
         endcase
         mul_b = mul_a;
      end

      case (cnt_lo)
         2'd0:    add_sum = (SUM_BITS+1)'($signed(row_ff[0]))
                            + (SUM_BITS+1)'(cross_ff[0]);
         2'd1:    add_sum = (SUM_BITS+1)'($signed(row_ff[1]))
                            + (SUM_BITS+1)'(cross_ff[1]);
         default: add_sum = (SUM_BITS+1)'($signed(row_ff[2]))
                            + (SUM_BITS+1)'(cross_ff[2]);
      endcase

      for (int i = 0; i < 3; i++) begin
         rd_mag[i] = mag_of(sum_rd_ff[i]);
      end
      rd_big = rd_mag[0];
      if (rd_mag[1] > rd_big) rd_big = rd_mag[1];
      if (rd_mag[2] > rd_big) rd_big = rd_mag[2];

      root_n = ROOT_BITS'(len2_ff);
      trial = NUM_BITS'(res_ff[LEN_BITS-1:0]) << div_shift;
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[vi_ff] <= pos_ff;
      end
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      cnt_ff <= (state_in != state_ff) ? '0 : cnt_ff + CNT_BITS'(1);
      prod_ff <= mul_a * mul_b;

      case (state_ff)
         S_IDLE: begin
            ci_ff     <= '0;
            vi_ff     <= req_tdata[VI_LSB +: IDX_BITS];
            pos_ff[0] <= req_tdata[PX_LSB +: COORD_BITS];
            pos_ff[1] <= req_tdata[PY_LSB +: COORD_BITS];
            pos_ff[2] <= req_tdata[PZ_LSB +: COORD_BITS];
            corner_ff[0] <= req_ca;
            corner_ff[1] <= req_cb;
            corner_ff[2] <= req_cc;
            skip_ff <= (action_type'(req_tuser) == ACT_TRI) && !tri_ok;
            sat_ff  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
               norm_ff[i] <= '0;
            end
         end
         S_TRI_RD: begin
            case (cnt_lo)
               2'd1:    p0_ff <= pos_rd_ff;
               2'd2:    p1_ff <= pos_rd_ff;
               2'd3:    p2_ff <= pos_rd_ff;
               default: p0_ff <= p0_ff;
            endcase
         end
         S_TRI_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               da_ff[i] <= DIFF_BITS'($signed(p1_ff[i])) - DIFF_BITS'($signed(p0_ff[i]));
               db_ff[i] <= DIFF_BITS'($signed(p2_ff[i])) - DIFF_BITS'($signed(p0_ff[i]));
            end
         end
         S_TRI_MUL: begin
            case (cnt_ff[2:0])
               3'd1: cross_ff[0] <= prod_ff[CROSS_BITS-1:0];
               3'd2: cross_ff[0] <= cross_ff[0] - $signed(prod_ff[CROSS_BITS-1:0]);
               3'd3: cross_ff[1] <= prod_ff[CROSS_BITS-1:0];
               3'd4: cross_ff[1] <= cross_ff[1] - $signed(prod_ff[CROSS_BITS-1:0]);
               3'd5: cross_ff[2] <= prod_ff[CROSS_BITS-1:0];
               3'd6: cross_ff[2] <= cross_ff[2] - $signed(prod_ff[CROSS_BITS-1:0]);
               default: cross_ff[0] <= cross_ff[0];
            endcase
         end
         S_SUM_WAIT: begin
            row_ff <= sum_rd_ff;
         end
         S_SUM_ADD: begin
            if (add_sum[SUM_BITS] != add_sum[SUM_BITS-1]) begin
               row_ff[cnt_lo] <= add_sum[SUM_BITS] ? SUM_LO : SUM_HI;
               sat_ff <= 1'b1;
            end else begin
               row_ff[cnt_lo] <= add_sum[SUM_BITS-1:0];
            end
         end
         S_SUM_WR: begin
            ci_ff <= ci_ff + 2'd1;
         end
         S_RD_WAIT: begin
            for (int i = 0; i < 3; i++) begin
               m_ff[i]   <= rd_mag[i];
               neg_ff[i] <= sum_rd_ff[i][SUM_BITS-1];
            end
            big_ff <= rd_big;
         end
         S_SHIFT: begin
            if (big_ff >= MAG_LIMIT) begin
               for (int i = 0; i < 3; i++) begin
                  m_ff[i] <= m_ff[i] >> 1;
               end
               big_ff <= big_ff >> 1;
            end
         end
         S_SQ: begin
            if (cnt_lo == 2'd0) begin
               len2_ff <= '0;
            end else begin
               len2_ff <= len2_ff + prod_ff;
            end
            res_ff <= '0;
            bit_ff <= ROOT_BITS'(1) << (2 * (SQRT_STEPS - 1));
         end
         S_SQRT: begin
            if (root_n >= res_ff + bit_ff) begin
               len2_ff <= PROD_BITS'(root_n - (res_ff + bit_ff));
               res_ff  <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         S_DIV_INIT: begin
            rem_ff <= NUM_BITS'({m_ff[ci_ff][MAG_BITS-1:0], FRAC_BITS'(0)})
                      + NUM_BITS'(res_ff[LEN_BITS-1:1]);
            quo_ff <= '0;
         end
         S_DIV: begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               quo_ff[div_shift] <= 1'b1;
            end
         end
         S_DIV_END: begin
            if (res_ff == '0) begin
               norm_ff[ci_ff] <= '0;
            end else if (neg_ff[ci_ff]) begin
               norm_ff[ci_ff] <= -$signed(NORM_BITS'(quo_ff));
            end else begin
               norm_ff[ci_ff] <= $signed(NORM_BITS'(quo_ff));
            end
            ci_ff <= ci_ff + 2'd1;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_data_ff <= {norm_ff[2], norm_ff[1], norm_ff[0]};
               rsp_user_ff <= {sat_ff, skip_ff};
            end
         end
         default: begin
            ci_ff <= ci_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_NEVER(a_skip_no_sat, clock, reset,
      rsp_tvalid && rsp_tuser[0] && rsp_tuser[1], "skipped triangle reported saturation")
   `ASSERT_PROP(a_load_seq, clock, reset,
      (req_accept && req_tuser == ACT_LOAD) |=> (state_ff == S_LOAD),
      "load did not enter write state")
   `ASSERT_PROP(a_quo_bound, clock, reset,
      (state_ff == S_DIV_END && res_ff != '0) |-> (quo_ff <= QUO_BITS'(16384)),
      "normal component exceeds one")

endmodule

`default_nettype wire
